>>> hdl/plb_pkg.sv
package plb_pkg;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [2:0] ST_UPDATED    = 3'd0;
  localparam logic [2:0] ST_INSERTED   = 3'd1;
  localparam logic [2:0] ST_REMOVED    = 3'd2;
  localparam logic [2:0] ST_ABSENT     = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_CLEARED    = 3'd5;
  localparam logic [2:0] ST_READ_OK    = 3'd6;
  localparam logic [2:0] ST_READ_EMPTY = 3'd7;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic wr;
    logic bid;
    logic remove;
    logic insert;
    logic overwrite;
  } plb_ctl_t;

endpackage

>>> hdl/price_level_book.sv
// Channel | direction | handshake          | payload
// in      | input     | in_valid/in_stall  | op, book_index, bid_side, level_price_in,
//         |           |                    | level_size_in, depth_index
// out     | output    | out_valid/out_stall| status, level_price_out, level_size_out,
//         |           |                    | side_count
//
// Each word first reads the side's column from every cell RAM and the count RAM,
// then the cells compare, shift and write back in parallel. No new word is taken
// until that write-back is done; the result is registered at the output.
// Reset (rst, synchronous) empties every side through per-side valid bits; the
// level RAMs are not cleared. One result may wait in a spare stage while out is
// stalled, so a word is still taken; input stalls in lookup or with both stages full.
module price_level_book #(
  parameter int DEPTH      = 16,
  parameter int NUM_BOOKS  = 2,
  parameter int PRICE_BITS = 16,
  parameter int SIZE_BITS  = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 op,
  input  logic                       book_index,
  input  logic                       bid_side,
  input  logic [15:0]                level_price_in,
  input  logic [31:0]                level_size_in,
  input  logic [3:0]                 depth_index,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 status,
  output logic [15:0]                level_price_out,
  output logic [31:0]                level_size_out,
  output logic [$clog2(DEPTH+1)-1:0] side_count
);

  localparam int NUM_SIDES = NUM_BOOKS * 2;
  localparam int SW        = $clog2(NUM_SIDES);
  localparam int CW        = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_LOOK = 1'b1;

  logic state;
  logic accept;

  logic                  book_eff;
  logic [SW-1:0]         side_in;
  logic [1:0]            op_q;
  logic                  book_q;
  logic                  bid_q;
  logic [SW-1:0]         side_q;
  logic [PRICE_BITS-1:0] price_q;
  logic [SIZE_BITS-1:0]  size_q;
  logic [3:0]            depth_q;

  logic [NUM_SIDES-1:0]  side_valid;
  logic [CW-1:0]         cnt_rdata;
  logic [CW-1:0]         n;
  logic [CW-1:0]         n_new;
  logic                  cnt_we;

  plb_pkg::plb_ctl_t     ctl;

  logic [PRICE_BITS-1:0] cell_price [DEPTH];
  logic [SIZE_BITS-1:0]  cell_size  [DEPTH];
  logic [DEPTH-1:0]      cell_ge;
  logic [DEPTH-1:0]      cell_match;
  logic                  found;
  logic                  full;
  logic                  size_zero;

  logic [2:0]            res_status;
  logic [PRICE_BITS-1:0] res_price;
  logic [SIZE_BITS-1:0]  res_size;
  logic [CW-1:0]         res_count;

  logic                  hold_valid;
  logic [2:0]            hold_status;
  logic [PRICE_BITS-1:0] hold_price;
  logic [SIZE_BITS-1:0]  hold_size;
  logic [CW-1:0]         hold_count;
  logic                  drain;
  logic                  load_out;
  logic                  load_hold;
  logic                  move_hold;

  assign in_stall = (state != S_IDLE) || hold_valid;
  assign accept   = in_valid && !in_stall;

  // book index wraps to zero when there is only one book
  assign book_eff = (NUM_BOOKS > 1) ? book_index : 1'b0;
  assign side_in  = SW'({book_eff, bid_side});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (accept) state <= S_LOOK;
        S_LOOK:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= op;
      book_q  <= book_eff;
      bid_q   <= bid_side;
      side_q  <= side_in;
      price_q <= PRICE_BITS'(level_price_in);
      size_q  <= SIZE_BITS'(level_size_in);
      depth_q <= depth_index;
    end
  end

  // counts: RAM behind per-side valid bits, an invalid side reads as empty
  assign n = side_valid[side_q] ? cnt_rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_valid <= '0;
    end else if (state == S_LOOK) begin
      if (op_q == plb_pkg::OP_CLEAR) begin
        side_valid[SW'({book_q, 1'b0})] <= 1'b0;
        side_valid[SW'({book_q, 1'b1})] <= 1'b0;
      end else if (cnt_we) begin
        side_valid[side_q] <= 1'b1;
      end
    end
  end

  plb_ram #(
    .WIDTH(CW),
    .DEPTH(NUM_SIDES)
  ) u_cnt_ram (
    .clk  (clk),
    .we   (cnt_we),
    .waddr(side_q),
    .wdata(n_new),
    .re   (accept),
    .raddr(side_in),
    .rdata(cnt_rdata)
  );

  assign found     = |cell_match;
  assign full      = (n == FULL_COUNT);
  assign size_zero = (size_q == '0);

  always_comb begin
    ctl.wr        = (state == S_LOOK);
    ctl.bid       = bid_q;
    ctl.remove    = (op_q == plb_pkg::OP_UPDATE) && size_zero && found;
    ctl.insert    = (op_q == plb_pkg::OP_UPDATE) && !size_zero && !found && !full;
    ctl.overwrite = (op_q == plb_pkg::OP_UPDATE) && !size_zero && found;
  end

  assign cnt_we = ctl.wr && (ctl.remove || ctl.insert);
  assign n_new  = ctl.remove ? (n - CW'(1)) : (n + CW'(1));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  prev_ge;
    logic [PRICE_BITS-1:0] prev_price;
    logic [SIZE_BITS-1:0]  prev_size;
    logic [PRICE_BITS-1:0] next_price;
    logic [SIZE_BITS-1:0]  next_size;

    if (i == 0) begin : g_head
      assign prev_ge    = 1'b0;
      assign prev_price = cell_price[i];
      assign prev_size  = cell_size[i];
    end else begin : g_mid
      assign prev_ge    = cell_ge[i-1];
      assign prev_price = cell_price[i-1];
      assign prev_size  = cell_size[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_price = cell_price[i];
      assign next_size  = cell_size[i];
    end else begin : g_body
      assign next_price = cell_price[i+1];
      assign next_size  = cell_size[i+1];
    end

    plb_cell #(
      .DEPTH     (DEPTH),
      .NUM_SIDES (NUM_SIDES),
      .PRICE_BITS(PRICE_BITS),
      .SIZE_BITS (SIZE_BITS),
      .IDX       (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .re        (accept),
      .raddr     (side_in),
      .waddr     (side_q),
      .key_price (price_q),
      .key_size  (size_q),
      .count     (n),
      .prev_ge   (prev_ge),
      .prev_price(prev_price),
      .prev_size (prev_size),
      .next_price(next_price),
      .next_size (next_size),
      .price     (cell_price[i]),
      .size      (cell_size[i]),
      .ge        (cell_ge[i]),
      .match     (cell_match[i])
    );
  end

  always_comb begin
    res_status = plb_pkg::ST_ABSENT;
    res_price  = '0;
    res_size   = '0;
    res_count  = n;
    unique case (op_q)
      plb_pkg::OP_UPDATE: begin
        priority if (ctl.remove) begin
          res_status = plb_pkg::ST_REMOVED;
          res_count  = n_new;
        end else if (size_zero) begin
          res_status = plb_pkg::ST_ABSENT;
        end else if (found) begin
          res_status = plb_pkg::ST_UPDATED;
        end else if (full) begin
          res_status = plb_pkg::ST_FULL;
        end else begin
          res_status = plb_pkg::ST_INSERTED;
          res_count  = n_new;
        end
      end
      plb_pkg::OP_CLEAR: begin
        res_status = plb_pkg::ST_CLEARED;
        res_count  = '0;
      end
      plb_pkg::OP_READ: begin
        res_status = plb_pkg::ST_READ_EMPTY;
        for (int i = 0; i < DEPTH; i++) begin
          if ((int'(depth_q) == i) && (i < int'(n))) begin
            res_status = plb_pkg::ST_READ_OK;
            res_price  = cell_price[i];
            res_size   = cell_size[i];
          end
        end
      end
      default: res_status = plb_pkg::ST_ABSENT;
    endcase
  end

  // output register with one spare stage behind it
  assign drain     = out_valid && !out_stall;
  assign load_out  = (state == S_LOOK) && (!out_valid || drain);
  assign load_hold = (state == S_LOOK) && out_valid && !drain;
  assign move_hold = (state != S_LOOK) && drain && hold_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (load_out || move_hold) begin
        out_valid <= 1'b1;
      end else if (drain) begin
        out_valid <= 1'b0;
      end
      if (load_hold) begin
        hold_valid <= 1'b1;
      end else if (move_hold) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status          <= res_status;
      level_price_out <= 16'(res_price);
      level_size_out  <= 32'(res_size);
      side_count      <= res_count;
    end else if (move_hold) begin
      status          <= hold_status;
      level_price_out <= 16'(hold_price);
      level_size_out  <= 32'(hold_size);
      side_count      <= hold_count;
    end
    if (load_hold) begin
      hold_status <= res_status;
      hold_price  <= res_price;
      hold_size   <= res_size;
      hold_count  <= res_count;
    end
  end

`ifndef NO_ASSERTIONS
  a_hold_behind_out: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> out_valid)
    else $error("spare stage full while output register empty");

  a_accept_look: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_LOOK))
    else $error("accepted word did not enter lookup");

  a_look_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK) |=> (state == S_IDLE) && out_valid)
    else $error("lookup did not finish with a result");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == plb_pkg::ST_INSERTED)) |-> (side_count != '0))
    else $error("insert reported an empty side");
`endif

endmodule

>>> hdl/plb_ram.sv
module plb_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/plb_cell.sv
module plb_cell #(
  parameter int DEPTH      = 16,
  parameter int NUM_SIDES  = 4,
  parameter int PRICE_BITS = 16,
  parameter int SIZE_BITS  = 32,
  parameter int IDX        = 0
) (
  input  logic                           clk,
  input  plb_pkg::plb_ctl_t              ctl,
  input  logic                           re,
  input  logic [$clog2(NUM_SIDES)-1:0]   raddr,
  input  logic [$clog2(NUM_SIDES)-1:0]   waddr,
  input  logic [PRICE_BITS-1:0]          key_price,
  input  logic [SIZE_BITS-1:0]           key_size,
  input  logic [$clog2(DEPTH+1)-1:0]     count,
  input  logic                           prev_ge,
  input  logic [PRICE_BITS-1:0]          prev_price,
  input  logic [SIZE_BITS-1:0]           prev_size,
  input  logic [PRICE_BITS-1:0]          next_price,
  input  logic [SIZE_BITS-1:0]           next_size,
  output logic [PRICE_BITS-1:0]          price,
  output logic [SIZE_BITS-1:0]           size,
  output logic                           ge,
  output logic                           match
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] POS = CW'(IDX);

  logic                           in_use;
  logic                           behind;
  logic                           we;
  logic [PRICE_BITS+SIZE_BITS-1:0] wdata;
  logic [PRICE_BITS+SIZE_BITS-1:0] rdata;

  assign price = rdata[PRICE_BITS+SIZE_BITS-1:SIZE_BITS];
  assign size  = rdata[SIZE_BITS-1:0];

  assign in_use = POS < count;
  assign match  = in_use && (price == key_price);
  assign behind = in_use && (ctl.bid ? (price < key_price) : (price > key_price));
  // from the insert point onwards every cell is behind or unused
  assign ge     = behind || !in_use;

  always_comb begin
    we    = 1'b0;
    wdata = rdata;
    if (ctl.wr) begin
      if (ctl.remove) begin
        // close the gap: take the neighbour behind
        we    = match || behind;
        wdata = {next_price, next_size};
      end else if (ctl.insert) begin
        if (ge && !prev_ge) begin
          we    = 1'b1;
          wdata = {key_price, key_size};
        end else if (prev_ge) begin
          we    = 1'b1;
          wdata = {prev_price, prev_size};
        end
      end else if (ctl.overwrite) begin
        we    = match;
        wdata = {price, key_size};
      end
    end
  end

  plb_ram #(
    .WIDTH(PRICE_BITS + SIZE_BITS),
    .DEPTH(NUM_SIDES)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule

>>> sim/tb_price_level_book.sv
`timescale 1ns / 1ps

module tb_price_level_book;

  localparam int DEPTH = 16;
  localparam int NUM_SIDES = 4;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_LEVELS = 24;

  typedef struct packed {
    logic [1:0]  op;
    logic        book;
    logic        bid;
    logic [15:0] price;
    logic [31:0] size;
    logic [3:0]  depth;
  } book_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] price;
    logic [31:0] size;
    logic [4:0]  count;
  } level_result_t;

  class level_book_board;
    logic [15:0]   prices [NUM_SIDES][DEPTH];
    logic [31:0]   sizes  [NUM_SIDES][DEPTH];
    int unsigned   counts [NUM_SIDES];
    level_result_t due_q [$];
    int            errors;
    int            words;
    int            seen [8];

    function new();
      foreach (counts[i]) counts[i] = 0;
      foreach (seen[i]) seen[i] = 0;
      errors = 0;
      words = 0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function logic [2:0] apply_update(int side, logic bid, logic [15:0] price,
                                      logic [31:0] size);
      int n;
      int found;
      int pos;
      n = counts[side];
      found = n;
      for (int i = 0; i < n; i++) begin
        if (prices[side][i] == price) begin
          found = i;
          break;
        end
      end
      if (size == 0) begin
        if (found >= n) return plb_pkg::ST_ABSENT;
        // close the gap left by the removed level
        for (int i = found; i + 1 < n; i++) begin
          prices[side][i] = prices[side][i+1];
          sizes[side][i]  = sizes[side][i+1];
        end
        counts[side] = n - 1;
        return plb_pkg::ST_REMOVED;
      end
      if (found < n) begin
        sizes[side][found] = size;
        return plb_pkg::ST_UPDATED;
      end
      if (n >= DEPTH) return plb_pkg::ST_FULL;
      pos = n;
      for (int i = 0; i < n; i++) begin
        if (bid ? (prices[side][i] < price) : (prices[side][i] > price)) begin
          pos = i;
          break;
        end
      end
      for (int i = n; i > pos; i--) begin
        prices[side][i] = prices[side][i-1];
        sizes[side][i]  = sizes[side][i-1];
      end
      prices[side][pos] = price;
      sizes[side][pos]  = size;
      counts[side] = n + 1;
      return plb_pkg::ST_INSERTED;
    endfunction

    function void note_word(book_word_t w);
      level_result_t r;
      int side;
      r = '0;
      side = 2 * int'(w.book) + int'(w.bid);
      case (w.op)
        plb_pkg::OP_UPDATE: r.status = apply_update(side, w.bid, w.price, w.size);
        plb_pkg::OP_CLEAR: begin
          counts[2 * int'(w.book)]     = 0;
          counts[2 * int'(w.book) + 1] = 0;
          r.status = plb_pkg::ST_CLEARED;
        end
        plb_pkg::OP_READ: begin
          if (w.depth < counts[side]) begin
            r.status = plb_pkg::ST_READ_OK;
            r.price  = prices[side][w.depth];
            r.size   = sizes[side][w.depth];
          end else begin
            r.status = plb_pkg::ST_READ_EMPTY;
          end
        end
        default: r.status = plb_pkg::ST_ABSENT;
      endcase
      r.count = 5'(counts[side]);
      due_q = {due_q, r};
      words++;
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(level_result_t got);
      level_result_t want;
      if (due_q.size() == 0) begin
        $display("%0t: result word with nothing pending, status %0d", $time, got.status);
        errors++;
        return;
      end
      want = due_q.pop_front();
      seen[want.status]++;
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("level_price_out", 32'(want.price), 32'(got.price));
      compare_field("level_size_out", want.size, got.size);
      compare_field("side_count", 32'(want.count), 32'(got.count));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  op = '0;
  logic        book_index = 1'b0;
  logic        bid_side = 1'b0;
  logic [15:0] level_price_in = '0;
  logic [31:0] level_size_in = '0;
  logic [3:0]  depth_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [15:0] level_price_out;
  logic [31:0] level_size_out;
  logic [4:0]  side_count;

  level_book_board board;
  int idle_pct = 35;
  int cycles = 0;

  // random word shaping for the current phase
  int  pool_base;
  int  pool_step;
  int  remove_pct;
  bit  focus;
  logic focus_book;
  logic focus_bid;

  price_level_book uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .book_index     (book_index),
    .bid_side       (bid_side),
    .level_price_in (level_price_in),
    .level_size_in  (level_size_in),
    .depth_index    (depth_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .level_price_out(level_price_out),
    .level_size_out (level_size_out),
    .side_count     (side_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, board.pending());
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    level_result_t got;
    got.status = status;
    got.price  = level_price_out;
    got.size   = level_size_out;
    got.count  = side_count;
    if (!rst && out_valid && !out_stall) board.check_result(got);
  end

  function automatic book_word_t mk(logic [1:0] o, logic bk, logic bd, logic [15:0] pr,
                                    logic [31:0] sz, logic [3:0] dp);
    book_word_t w;
    w.op = o;
    w.book = bk;
    w.bid = bd;
    w.price = pr;
    w.size = sz;
    w.depth = dp;
    return w;
  endfunction

  function automatic book_word_t rand_word();
    book_word_t w;
    int r;
    w.op    = plb_pkg::OP_UPDATE;
    w.book  = 1'($urandom_range(1));
    w.bid   = 1'($urandom_range(1));
    w.price = 16'($urandom);
    w.size  = $urandom;
    w.depth = 4'($urandom_range(15));
    if (focus && $urandom_range(99) < 80) begin
      w.book = focus_book;
      w.bid  = focus_bid;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      w.op = plb_pkg::OP_CLEAR;
    end else if (r < 5) begin
      w.op = OP_UNUSED;
    end else if (r < 25) begin
      w.op = plb_pkg::OP_READ;
    end else begin
      // mostly prices from a small ladder so levels meet again
      if ($urandom_range(99) < 90)
        w.price = 16'(pool_base + pool_step * $urandom_range(POOL_LEVELS - 1));
      if ($urandom_range(99) < remove_pct)
        w.size = '0;
      else if ($urandom_range(1))
        w.size = 32'($urandom_range(1, 1000));
      else if (w.size == 0)
        w.size = 32'd1;
    end
    return w;
  endfunction

  task automatic send_word(input book_word_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    op             <= w.op;
    book_index     <= w.book;
    bid_side       <= w.bid;
    level_price_in <= w.price;
    level_size_in  <= w.size;
    depth_index    <= w.depth;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_word(w);
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty reads, extremes, overwrite, removal, unused op, clear
    send_word(mk(plb_pkg::OP_READ,   1'b0, 1'b0, 16'h0000, 32'h0000_0000, 4'd0));
    send_word(mk(plb_pkg::OP_UPDATE, 1'b0, 1'b1, 16'h1234, 32'h0000_0000, 4'd0));
    send_word(mk(plb_pkg::OP_UPDATE, 1'b0, 1'b1, 16'h0000, 32'hFFFF_FFFF, 4'd0));
    send_word(mk(plb_pkg::OP_UPDATE, 1'b0, 1'b1, 16'hFFFF, 32'h0000_0001, 4'd0));
    send_word(mk(plb_pkg::OP_UPDATE, 1'b0, 1'b1, 16'h8000, 32'h8000_0000, 4'd0));
    send_word(mk(plb_pkg::OP_UPDATE, 1'b0, 1'b1, 16'hFFFF, 32'h0000_0002, 4'd0));
    send_word(mk(plb_pkg::OP_READ,   1'b0, 1'b1, 16'h0000, 32'h0000_0000, 4'd0));
    send_word(mk(plb_pkg::OP_READ,   1'b0, 1'b1, 16'h0000, 32'h0000_0000, 4'd1));
    send_word(mk(plb_pkg::OP_READ,   1'b0, 1'b1, 16'h0000, 32'h0000_0000, 4'd2));
    send_word(mk(plb_pkg::OP_READ,   1'b0, 1'b1, 16'h0000, 32'h0000_0000, 4'd3));
    send_word(mk(plb_pkg::OP_READ,   1'b0, 1'b1, 16'h0000, 32'h0000_0000, 4'd15));
    send_word(mk(plb_pkg::OP_UPDATE, 1'b1, 1'b0, 16'h7FFF, 32'h0000_0005, 4'd0));
    send_word(mk(plb_pkg::OP_UPDATE, 1'b1, 1'b0, 16'h0001, 32'h0000_0003, 4'd0));
    send_word(mk(plb_pkg::OP_UPDATE, 1'b1, 1'b0, 16'hFFFE, 32'hFFFF_FFFE, 4'd0));
    send_word(mk(plb_pkg::OP_UPDATE, 1'b1, 1'b0, 16'h0000, 32'h0000_0001, 4'd0));
    send_word(mk(plb_pkg::OP_READ,   1'b1, 1'b0, 16'h0000, 32'h0000_0000, 4'd0));
    send_word(mk(plb_pkg::OP_READ,   1'b1, 1'b0, 16'h0000, 32'h0000_0000, 4'd3));
    send_word(mk(plb_pkg::OP_UPDATE, 1'b0, 1'b1, 16'h8000, 32'h0000_0000, 4'd0));
    send_word(mk(plb_pkg::OP_READ,   1'b0, 1'b1, 16'h0000, 32'h0000_0000, 4'd1));
    send_word(mk(OP_UNUSED,          1'b0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 4'hF));
    send_word(mk(plb_pkg::OP_CLEAR,  1'b1, 1'b1, 16'h0000, 32'h0000_0000, 4'd0));
    send_word(mk(plb_pkg::OP_READ,   1'b1, 1'b0, 16'h0000, 32'h0000_0000, 4'd0));
    send_word(mk(plb_pkg::OP_CLEAR,  1'b0, 1'b0, 16'h5555, 32'h0000_0000, 4'd0));
    send_word(mk(plb_pkg::OP_READ,   1'b0, 1'b1, 16'h0000, 32'h0000_0000, 4'd0));

    // random phases; the first fills one side hard to reach the full case
    for (int ph = 0; ph < 13; ph++) begin
      pool_step  = $urandom_range(1, 40);
      pool_base  = $urandom_range(0, 65535 - (POOL_LEVELS - 1) * pool_step);
      remove_pct = (ph == 0) ? 5 : $urandom_range(10, 45);
      focus      = (ph % 3 == 0);
      focus_book = 1'($urandom_range(1));
      focus_bid  = 1'($urandom_range(1));
      idle_pct   = (ph == 6) ? 0 : 35;
      for (int k = 0; k < 100; k++) send_word(rand_word());
    end

    in_valid <= 1'b0;
    idle_pct = 35;
    while (board.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d words: %0d inserted, %0d updated, %0d removed, %0d absent, %0d full",
             board.words, board.seen[plb_pkg::ST_INSERTED], board.seen[plb_pkg::ST_UPDATED],
             board.seen[plb_pkg::ST_REMOVED], board.seen[plb_pkg::ST_ABSENT],
             board.seen[plb_pkg::ST_FULL]);
    $display("%0d clears, %0d reads of a level, %0d reads past the count, %0d errors",
             board.seen[plb_pkg::ST_CLEARED], board.seen[plb_pkg::ST_READ_OK],
             board.seen[plb_pkg::ST_READ_EMPTY], board.errors);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
